// ===== sv/lmw_pkg.sv =====
// Shared types, constants and helpers for the lexicographic max word block.
package lmw_pkg;

   localparam int MAX_WORD_LEN_DEF = 32;
   localparam int CHAR_W           = 8;
   localparam int USER_W           = 3;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTE,
      ST_CLOSE,
      ST_FETCH,
      ST_SHOW
   } state_type;

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

// ===== sv/lmw_word_ram.sv =====
// Two-bank word store: one write port, one read port with registered data.
module lmw_word_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lexicographic_max_word.sv =====
// Top level: greatest word of a byte stream, by byte value, emitted per character.
// Each input byte is handled as a store read, then a compare/write; input is ready again after that.
// The final byte adds a close state, then each result character is a store read, then a show held until taken.
// The single read port of the word store is shared by compare and emission.
// Synchronous active-high reset: idle, no error, empty words; store contents stay unknown.
module lexicographic_max_word #(
   parameter int MAX_WORD_LEN = lmw_pkg::MAX_WORD_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [lmw_pkg::CHAR_W-1:0] req_tdata,  // [7:0] char_in
   input  logic                       req_tlast,  // end_of_sentence
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [lmw_pkg::CHAR_W-1:0] rsp_tdata,  // [7:0] char_out
   output logic [lmw_pkg::USER_W-1:0] rsp_tuser,  // [1:0] status, [2] word_empty
   output logic                       rsp_tlast   // last_out
);

   import lmw_pkg::*;

   localparam int IDX_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
   localparam int ADDR_W = IDX_W + 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_LEN);

   state_type         state_ff, state_in;
   status_type        err_ff, err_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              eos_ff, eos_in;
   logic              bank_ff, bank_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic              bigger_ff, bigger_in;
   logic              peq_ff, peq_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CHAR_W-1:0] rd_data;

   logic              show_err;
   logic              show_empty;
   logic              show_last;

   lmw_word_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (CHAR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (char_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign show_err   = (err_ff != STATUS_OK);
   assign show_empty = !show_err && (best_len_ff == '0);
   assign show_last  = show_err || show_empty ||
                       ((LEN_W'(out_idx_ff) + LEN_W'(1)) == best_len_ff);

   assign rsp_tdata = (show_err || show_empty) ? '0 : rd_data;
   assign rsp_tuser = {show_empty, err_ff};
   assign rsp_tlast = show_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         err_ff      <= STATUS_OK;
         bank_ff     <= 1'b0;
         best_len_ff <= '0;
         cur_len_ff  <= '0;
         bigger_ff   <= 1'b0;
         peq_ff      <= 1'b1;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         err_ff      <= err_in;
         bank_ff     <= bank_in;
         best_len_ff <= best_len_in;
         cur_len_ff  <= cur_len_in;
         bigger_ff   <= bigger_in;
         peq_ff      <= peq_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      eos_ff  <= eos_in;
   end

   always_comb begin
      state_in    = state_ff;
      err_in      = err_ff;
      char_in     = char_ff;
      eos_in      = eos_ff;
      bank_in     = bank_ff;
      best_len_in = best_len_ff;
      cur_len_in  = cur_len_ff;
      bigger_in   = bigger_ff;
      peq_in      = peq_ff;
      out_idx_in  = out_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = {~bank_ff, cur_len_ff[IDX_W-1:0]};
      rd_en       = 1'b0;
      rd_addr     = {bank_ff, cur_len_ff[IDX_W-1:0]};
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               char_in  = req_tdata;
               eos_in   = req_tlast;
               rd_en    = 1'b1;
               state_in = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (err_ff == STATUS_OK) begin
               priority if (char_ff == SPACE_CHAR) begin
                  if (bigger_ff) begin
                     bank_in     = ~bank_ff;
                     best_len_in = cur_len_ff;
                  end
                  cur_len_in = '0;
                  bigger_in  = 1'b0;
                  peq_in     = 1'b1;
               end else if (!is_letter(char_ff)) begin
                  err_in      = STATUS_BAD_CHAR;
                  best_len_in = '0;
                  cur_len_in  = '0;
                  bigger_in   = 1'b0;
                  peq_in      = 1'b1;
               end else if (cur_len_ff >= MAX_LEN) begin
                  err_in      = STATUS_TOO_LONG;
                  best_len_in = '0;
                  cur_len_in  = '0;
                  bigger_in   = 1'b0;
                  peq_in      = 1'b1;
               end else begin
                  wr_en      = 1'b1;
                  cur_len_in = cur_len_ff + LEN_W'(1);
                  if (peq_ff) begin
                     priority if (cur_len_ff >= best_len_ff) begin
                        bigger_in = 1'b1;
                     end else if (rd_data > char_ff) begin
                        peq_in = 1'b0;
                     end else if (rd_data < char_ff) begin
                        bigger_in = 1'b1;
                        peq_in    = 1'b0;
                     end else begin
                        peq_in = 1'b1;
                     end
                  end
               end
            end
            state_in = eos_ff ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            // implicit space after the final byte
            if ((err_ff == STATUS_OK) && bigger_ff) begin
               bank_in     = ~bank_ff;
               best_len_in = cur_len_ff;
            end
            cur_len_in = '0;
            bigger_in  = 1'b0;
            peq_in     = 1'b1;
            out_idx_in = '0;
            state_in   = ST_FETCH;
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = {bank_ff, out_idx_ff};
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (show_last) begin
                  err_in      = STATUS_OK;
                  best_len_in = '0;
                  cur_len_in  = '0;
                  bigger_in   = 1'b0;
                  peq_in      = 1'b1;
                  out_idx_in  = '0;
                  state_in    = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + IDX_W'(1);
                  state_in   = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/lmw_checker.sv =====
// Port-level checker for the lexicographic max word block, with its bind.
module lmw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   import lmw_pkg::*;

   // one item at a time: never taking input while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while result offered");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1:0] == STATUS_OK || rsp_tuser[1:0] == STATUS_BAD_CHAR ||
                      rsp_tuser[1:0] == STATUS_TOO_LONG))
      else $error("bad status code");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] != STATUS_OK) |->
         (rsp_tlast && rsp_tdata == 8'h00 && !rsp_tuser[2]))
      else $error("error result malformed");

   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tlast && rsp_tdata == 8'h00))
      else $error("empty result malformed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind lexicographic_max_word lmw_checker u_lmw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
